// File: sv/bfcw_pkg.sv
// ----------------------------------------------------------------------------
// bfcw_pkg: shared types and constants for the clipped box filter
// Field widths, default image size, command codes and controller states.
// ----------------------------------------------------------------------------
package bfcw_pkg;

  localparam int IMAGE_WIDTH_DEF  = 224;
  localparam int IMAGE_HEIGHT_DEF = 224;

  localparam int RADIUS_W = 4;
  localparam int VALUE_W  = 8;
  localparam int COORD_IN_W = 8;
  localparam int SUM_W    = 24;
  // window side is at most 2*15+1 = 31 pixels
  localparam int SPAN_W   = 5;
  localparam int COUNT_W  = 2 * SPAN_W;
  // remainder stays below count*256
  localparam int REM_W    = COUNT_W + VALUE_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd5;
  localparam logic [VALUE_W-1:0]  VALUE_MAX    = 8'hFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_RD_CLIP,
    ST_RD_ISSUE,
    ST_RD_DRAIN,
    ST_RD_DIV,
    ST_RD_WAIT,
    ST_RD_OUT
  } state_t;

  // four corners of the window sum, in issue order
  typedef enum logic [1:0] {
    CRN_BR,   // (y2, x2)       added
    CRN_TR,   // (y1-1, x2)     subtracted
    CRN_BL,   // (y2, x1-1)     subtracted
    CRN_TL    // (y1-1, x1-1)   added
  } corner_t;

  typedef struct packed {
    logic start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

endpackage

// File: sv/bfcw_tbl_mem.sv
// ----------------------------------------------------------------------------
// bfcw_tbl_mem: summed-area table storage
// One write port and one registered read port; data is returned in the cycle after re.
// ----------------------------------------------------------------------------
module bfcw_tbl_mem #(
  parameter int DEPTH  = 50176,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bfcw_div.sv
// ----------------------------------------------------------------------------
// bfcw_div: saturating 8-bit quotient divider
// Restoring division, one quotient bit per cycle; quotients above 255
// are caught up front and return 255.
// ----------------------------------------------------------------------------
module bfcw_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bfcw_pkg::div_req_t        req,
  output logic                      done,
  output logic [bfcw_pkg::VALUE_W-1:0] quotient
);
  import bfcw_pkg::*;

  localparam int DSH_W = COUNT_W + VALUE_W - 1;

  logic               busy_r;
  logic [2:0]         step_r;
  logic [REM_W-1:0]   rem_r;
  logic [DSH_W-1:0]   dsh_r;
  logic [VALUE_W-1:0] quo_r;
  logic               done_r;
  logic               sat;
  logic               ge;

  // quotient would exceed 8 bits
  assign sat = req.dividend >= SUM_W'({req.divisor, {VALUE_W{1'b0}}});
  assign ge  = rem_r >= REM_W'(dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= !sat;
        done_r <= sat;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[REM_W-1:0];
      dsh_r <= {req.divisor, {(VALUE_W-1){1'b0}}};
      quo_r <= sat ? VALUE_MAX : '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - REM_W'(dsh_r);
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[VALUE_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/box_filter_clipped_window_core.sv
// ----------------------------------------------------------------------------
// box_filter_clipped_window_core: box-mean filter from a summed-area table
// Builds the table from streamed mask bytes and answers clipped-window
// mean queries against it.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per command. in_tuser = command (0 load, 1 read).
//           Load words carry the next mask byte in raster order; the load
//           position advances on its own and wraps after a full frame.
//           Read words carry pixel_x / pixel_y; the result word on out_*
//           is the truncated mean of the window of radius window_radius,
//           clipped at the image borders.
//   cfg_* : cfg_wr_en writes window_radius (reset 5). Write only while idle.
//   One command is worked at a time; in_tready is high only while idle.
//   Load: per word, accept, read of the entry above, write of the new entry.
//   Read: four corner reads through the single table read port, then a
//   bit-serial divider, whose steps are skipped when the mean saturates at 255.
//   The divider's eight steps dominate.
//   The result sits in an output register; a stalled out_tready holds it,
//   and the next command is still accepted. A read that finishes while the
//   register is still full waits for it to drain.
//   Reset clears load position, row sum, radius and all handshake state.
//   Table contents are not cleared; reading rows never loaded is undefined.
// ----------------------------------------------------------------------------
module box_filter_clipped_window_core #(
  parameter int IMAGE_WIDTH  = bfcw_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = bfcw_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] mask_value, [15:8] pixel_x, [23:16] pixel_y
  input  logic        in_tuser,   // [0] command
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] soft_value
  // radius register
  input  logic        cfg_wr_en,
  input  logic [bfcw_pkg::RADIUS_W-1:0] cfg_wr_data
);
  import bfcw_pkg::*;

  localparam int DEPTH   = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_W   = $clog2(IMAGE_WIDTH);
  localparam int ROW_W   = $clog2(IMAGE_HEIGHT);
  localparam int RS_W    = $clog2(IMAGE_WIDTH * 255 + 1);
  localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int CW      = ($clog2(MAX_DIM) > COORD_IN_W) ? $clog2(MAX_DIM) : COORD_IN_W;

  localparam logic [CW-1:0]     XMAX    = CW'(IMAGE_WIDTH - 1);
  localparam logic [CW-1:0]     YMAX    = CW'(IMAGE_HEIGHT - 1);
  localparam logic [COL_W-1:0]  COL_END = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_END = ROW_W'(IMAGE_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] W_A     = ADDR_W'(IMAGE_WIDTH);

  // ---- control and config state ----
  state_t                state_r, state_nxt;
  logic [RADIUS_W-1:0]   radius_r;

  // ---- captured command ----
  logic [VALUE_W-1:0]    mask_r;
  logic [CW-1:0]         px_r, py_r;

  // ---- load position ----
  logic [COL_W-1:0]      load_col_r;
  logic [ROW_W-1:0]      load_row_r;
  logic [ADDR_W-1:0]     load_addr_r;   // load_row_r * IMAGE_WIDTH + load_col_r
  logic [RS_W-1:0]       rsum_r;

  // ---- clipped window ----
  logic [CW-1:0]         x1_r, x2_r, y1_r, y2_r;
  logic [COUNT_W-1:0]    count_r;
  corner_t               corner_r;

  // ---- corner read tracking ----
  logic                  rd_pend_r;
  logic                  rd_sub_r;
  logic                  rd_zero_r;
  logic [SUM_W-1:0]      acc_r;

  // ---- output register ----
  logic                  out_tvalid_r;
  logic [VALUE_W-1:0]    out_tdata_r;

  // ---- memory and divider hookup ----
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [SUM_W-1:0]      mem_wdata, mem_rdata;
  div_req_t              div_req;
  logic                  div_done;
  logic [VALUE_W-1:0]    div_quo;

  // ---- combinational helpers ----
  logic                  in_acc;
  logic                  out_load;
  logic [CW-1:0]         xs, ys, rad;
  logic [CW:0]           x2s, y2s;
  logic [CW-1:0]         x1_c, x2_c, y1_c, y2_c;
  logic [CW-1:0]         crow, ccol;
  logic                  czero, csub;
  logic [ADDR_W-1:0]     corner_addr;
  logic [SPAN_W-1:0]     span_x, span_y;
  logic [SUM_W-1:0]      above;
  logic [SUM_W-1:0]      term;

  assign in_acc = in_tvalid && in_tready;

  // clip: saturate coordinates, then clamp the window to the image
  assign xs   = (px_r > XMAX) ? XMAX : px_r;
  assign ys   = (py_r > YMAX) ? YMAX : py_r;
  assign rad  = CW'(radius_r);
  assign x1_c = (xs >= rad) ? xs - rad : '0;
  assign y1_c = (ys >= rad) ? ys - rad : '0;
  assign x2s  = {1'b0, xs} + {1'b0, rad};
  assign y2s  = {1'b0, ys} + {1'b0, rad};
  assign x2_c = (x2s > {1'b0, XMAX}) ? XMAX : x2s[CW-1:0];
  assign y2_c = (y2s > {1'b0, YMAX}) ? YMAX : y2s[CW-1:0];

  assign span_x = SPAN_W'(x2_r - x1_r) + SPAN_W'(1);
  assign span_y = SPAN_W'(y2_r - y1_r) + SPAN_W'(1);

  // corner select; a corner left of or above the image reads as zero
  always_comb begin
    crow  = y2_r;
    ccol  = x2_r;
    czero = 1'b0;
    csub  = 1'b0;
    case (corner_r)
      CRN_BR: begin
        crow  = y2_r;
        ccol  = x2_r;
      end
      CRN_TR: begin
        crow  = y1_r - CW'(1);
        ccol  = x2_r;
        czero = (y1_r == '0);
        csub  = 1'b1;
      end
      CRN_BL: begin
        crow  = y2_r;
        ccol  = x1_r - CW'(1);
        czero = (x1_r == '0);
        csub  = 1'b1;
      end
      CRN_TL: begin
        crow  = y1_r - CW'(1);
        ccol  = x1_r - CW'(1);
        czero = (y1_r == '0) || (x1_r == '0);
      end
      default: begin
        czero = 1'b1;
      end
    endcase
  end

  assign corner_addr = ADDR_W'(crow) * W_A + ADDR_W'(ccol);

  // new table entry: entry above plus running row sum
  assign above     = (load_row_r != '0) ? mem_rdata : '0;
  assign mem_wdata = above + SUM_W'(rsum_r);
  assign mem_waddr = load_addr_r;

  assign term = rd_zero_r ? '0 : mem_rdata;

  // ---- state register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- next state and strobes ----
  always_comb begin
    state_nxt        = state_r;
    in_tready        = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_raddr        = corner_addr;
    div_req.start    = 1'b0;
    div_req.dividend = acc_r;
    div_req.divisor  = count_r;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_tuser == CMD_READ) ? ST_RD_CLIP : ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        mem_re    = (load_row_r != '0);
        mem_raddr = load_addr_r - W_A;
        state_nxt = ST_LD_WR;
      end
      ST_LD_WR: begin
        mem_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD_CLIP: begin
        state_nxt = ST_RD_ISSUE;
      end
      ST_RD_ISSUE: begin
        mem_re = !czero;
        if (corner_r == CRN_TL) begin
          state_nxt = ST_RD_DRAIN;
        end
      end
      ST_RD_DRAIN: begin
        state_nxt = ST_RD_DIV;
      end
      ST_RD_DIV: begin
        div_req.start = 1'b1;
        state_nxt     = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (div_done) begin
          state_nxt = ST_RD_OUT;
        end
      end
      ST_RD_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---- radius register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // ---- command capture ----
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mask_r <= in_tdata[7:0];
      px_r   <= CW'(in_tdata[15:8]);
      py_r   <= CW'(in_tdata[23:16]);
    end
  end

  // ---- load position and row sum ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_col_r  <= '0;
      load_row_r  <= '0;
      load_addr_r <= '0;
      rsum_r      <= '0;
    end else begin
      if (state_r == ST_LD_RD) begin
        rsum_r <= ((load_col_r == '0) ? '0 : rsum_r) + RS_W'(mask_r);
      end
      if (state_r == ST_LD_WR) begin
        load_addr_r <= (load_addr_r == ADDR_END) ? '0 : load_addr_r + ADDR_W'(1);
        if (load_col_r == COL_END) begin
          load_col_r <= '0;
          load_row_r <= (load_row_r == ROW_END) ? '0 : load_row_r + ROW_W'(1);
        end else begin
          load_col_r <= load_col_r + COL_W'(1);
        end
      end
    end
  end

  // ---- window geometry and corner sequencing ----
  always_ff @(posedge clk) begin
    if (state_r == ST_RD_CLIP) begin
      x1_r     <= x1_c;
      x2_r     <= x2_c;
      y1_r     <= y1_c;
      y2_r     <= y2_c;
      corner_r <= CRN_BR;
    end
    if (state_r == ST_RD_ISSUE) begin
      corner_r <= corner_t'(2'(corner_r) + 2'd1);
      if (corner_r == CRN_BR) begin
        count_r <= COUNT_W'(span_x) * COUNT_W'(span_y);
      end
    end
  end

  // ---- corner accumulation, in the cycle after the read ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == ST_RD_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    rd_sub_r  <= csub;
    rd_zero_r <= czero;
    if (state_r == ST_RD_CLIP) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      acc_r <= rd_sub_r ? acc_r - term : acc_r + term;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= div_quo;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---- submodules ----
  bfcw_tbl_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SUM_W)
  ) u_tbl (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---- assertions ----
  a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    load_addr_r == ADDR_W'(load_row_r) * W_A + ADDR_W'(load_col_r))
    else $error("load address out of step with row/column");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_RD_WAIT)
    else $error("divider finished outside a read");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_RD_OUT))
    else $error("result word without a finished read");

endmodule

// File: tb/box_filter_clipped_window_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filter_clipped_window_core_tb: self-checking bench for the box filter
// Streams mask loads and window reads with random gaps on both sides. A
// scoreboard keeps its own summed table and predicts every mean. The run
// covers the first rows of a frame at several radii and top border probes.
// ----------------------------------------------------------------------------
module box_filter_clipped_window_core_tb;
  import bfcw_pkg::*;

  localparam int W           = IMAGE_WIDTH_DEF;
  localparam int H           = IMAGE_HEIGHT_DEF;
  localparam int PIX         = W * H;
  localparam int CYCLE_LIMIT = 2_000_000;
  // idle cycles before a radius write
  localparam int SETTLE      = 24;

  // --------------------------------------------------------------------------
  // Scoreboard: private summed table, load position and radius. Load words
  // extend the table; read words queue the expected mean.
  // --------------------------------------------------------------------------
  class box_mean_tracker;
    logic [SUM_W-1:0]    sums [PIX];
    logic [SUM_W-1:0]    row_sum;
    logic [RADIUS_W-1:0] radius;
    logic [VALUE_W-1:0]  mean_q [$];
    int ld_col, ld_row;
    int filled;   // entries written so far in the first frame
    int errors, n_loads, n_reads, n_sat, n_edge;

    function new();
      row_sum = '0;
      radius  = RADIUS_RESET;
      ld_col  = 0;
      ld_row  = 0;
      filled  = 0;
      errors  = 0;
      n_loads = 0;
      n_reads = 0;
      n_sat   = 0;
      n_edge  = 0;
    endfunction

    // rows/columns above or left of the image read as zero
    function logic [SUM_W-1:0] corner(int row, int col);
      if (row < 0 || col < 0) return '0;
      return sums[row * W + col];
    endfunction

    // saturate the coordinates, then clip the window at the borders
    function void clip_window(input logic [7:0] px, input logic [7:0] py,
                              output int x1, output int x2,
                              output int y1, output int y2);
      int x, y, r;
      x  = (px > W - 1) ? W - 1 : px;
      y  = (py > H - 1) ? H - 1 : py;
      r  = radius;
      x1 = (x - r < 0) ? 0 : x - r;
      y1 = (y - r < 0) ? 0 : y - r;
      x2 = (x + r > W - 1) ? W - 1 : x + r;
      y2 = (y + r > H - 1) ? H - 1 : y + r;
    endfunction

    // all four corners precede (y2, x2) in raster order
    function bit can_read(logic [7:0] px, logic [7:0] py);
      int x1, x2, y1, y2;
      clip_window(px, py, x1, x2, y1, y2);
      return (y2 * W + x2) < filled;
    endfunction

    function void note_word(logic cmd, logic [23:0] d);
      int x1, x2, y1, y2, idx, cnt, m, r;
      logic [SUM_W-1:0] above, wsum;
      if (cmd == CMD_LOAD) begin
        if (ld_col == 0) row_sum = '0;
        row_sum   = row_sum + d[7:0];
        idx       = ld_row * W + ld_col;
        above     = (ld_row > 0) ? sums[idx - W] : '0;
        sums[idx] = above + row_sum;
        if (filled < PIX) filled++;
        ld_col++;
        if (ld_col == W) begin
          ld_col = 0;
          ld_row = (ld_row == H - 1) ? 0 : ld_row + 1;
        end
        n_loads++;
      end else begin
        clip_window(d[15:8], d[23:16], x1, x2, y1, y2);
        // modulo 2^24, exact for a single-frame window
        wsum = corner(y2, x2) - corner(y1 - 1, x2)
             - corner(y2, x1 - 1) + corner(y1 - 1, x1 - 1);
        cnt  = (x2 - x1 + 1) * (y2 - y1 + 1);
        m    = int'(wsum) / cnt;
        r    = radius;
        if (m > 255) begin
          m = 255;
          n_sat++;
        end
        if (cnt < (2 * r + 1) * (2 * r + 1)) n_edge++;
        mean_q.push_back(m[VALUE_W-1:0]);
        n_reads++;
      end
    endfunction

    function void check_mean(logic [VALUE_W-1:0] got);
      logic [VALUE_W-1:0] want;
      if (mean_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: result word %0d with no read pending", got);
        return;
      end
      want = mean_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: mean expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return mean_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [23:0]         in_tdata;    // [7:0] mask_value, [15:8] pixel_x, [23:16] pixel_y
  logic                in_tuser;    // [0] command
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;   // [7:0] soft_value
  logic                cfg_wr_en;
  logic [RADIUS_W-1:0] cfg_wr_data;

  box_filter_clipped_window_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  box_mean_tracker trk;
  bit              calm;     // no gaps on either side while set
  int              cycles;

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads pending", cycles, trk.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result monitor: sampled at the rising edge, values from before the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) trk.check_mean(out_tdata);
  end

  // gap lengths: mostly none or short, a few long
  function automatic int gap_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // receiver: random stalls, changed only at the falling edge
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      n = gap_len();
      if (n > 0) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready = 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // one command word, optional gap first; returns at the accepting edge
  task automatic send_word(logic cmd, logic [23:0] d);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    trk.note_word(cmd, d);
  endtask

  // drop valid and hold off until every queued mean has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (trk.pending() != 0) @(posedge clk);
  endtask

  // radius writes only with the block idle
  task automatic set_radius(logic [RADIUS_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    trk.radius  = v;
  endtask

  // corners, edges and out-of-image coordinates
  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'(W - 1);
      2:       return 8'($urandom_range(W, 255));
      3:       return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random word. A read is tried only where every corner it touches was
  // written; otherwise the word turns into a load. Unused fields stay random.
  task automatic send_random(int read_pct);
    logic [23:0] d;
    logic [7:0]  x, y;
    bit          is_read;
    d       = 24'($urandom);
    is_read = 1'b0;
    if ($urandom_range(0, 149) == 0) wait_drained();
    if ($urandom_range(0, 99) < read_pct) begin
      for (int t = 0; t < 6; t++) begin
        x = pick_coord();
        y = (trk.filled < PIX) ? 8'($urandom_range(0, trk.ld_row)) : pick_coord();
        if (trk.can_read(x, y)) begin
          d[15:8]  = x;
          d[23:16] = y;
          is_read  = 1'b1;
          break;
        end
      end
    end
    if (!is_read && $urandom_range(0, 3) == 0)
      d[7:0] = $urandom_range(0, 1) ? VALUE_MAX : 8'h00;
    send_word(is_read ? CMD_READ : CMD_LOAD, d);
  endtask

  // fixed reads at the top corners, top center and beyond the right border;
  // a probe whose rows are not loaded yet is skipped
  task automatic probe_corners();
    logic [7:0] x, y;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0:       begin x = 8'd0;       y = 8'd0;  end
        1:       begin x = 8'(W - 1);  y = 8'd0;  end
        2:       begin x = 8'd255;     y = 8'd0;  end
        3:       begin x = 8'(W / 2);  y = 8'd0;  end
        4:       begin x = 8'd0;       y = 8'd1;  end
        default: begin x = 8'd255;     y = 8'd1;  end
      endcase
      if (trk.can_read(x, y)) send_word(CMD_READ, {y, x, 8'($urandom)});
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] v;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_LOAD;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b0;
    cycles      = 0;
    trk         = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed loads: full-scale/zero alternation, then a walking one
    for (int i = 0; i < 16; i++) begin
      v = (i < 8) ? ((i % 2) ? 8'h00 : VALUE_MAX) : 8'(1 << (i - 8));
      send_word(CMD_LOAD, {16'($urandom), v});
    end

    // first rows at small radii; reads stay inside the loaded rows
    set_radius(4'd0);
    repeat (300) send_random(40);
    set_radius(4'd1);
    repeat (300) send_random(40);
    set_radius(4'd2);
    repeat (300) send_random(40);

    // fill six rows back to back
    calm = 1'b1;
    while (trk.filled < 6 * W) send_random(10);
    calm = 1'b0;

    // top border probes, then reads at the default radius
    set_radius(4'd0);
    probe_corners();
    set_radius(RADIUS_RESET);
    probe_corners();
    repeat (80) send_random(50);

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d mask loads and %0d window reads over the first rows of a frame,",
             trk.n_loads, trk.n_reads);
    $display("radius 0 to 5; %0d windows clipped, %0d means saturated, %0d mismatches.",
             trk.n_edge, trk.n_sat, trk.errors);
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
